>>> rtl/xed_pkg.sv
// Shared types, constants and entity tables for the XML entity decoder.
package xed_pkg;

  localparam int unsigned ENT_COUNT = 5;
  localparam int unsigned GRP_MAX   = 6;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [4:0] ALL_CAND = 5'h1F;

  // Entity indexes, matching the candidate mask bit order
  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_LT   = 3'd1;
  localparam logic [2:0] ENT_GT   = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_APOS = 3'd4;

  // Bytes released by one item, first byte in slot 0
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } xed_group_t;

  // Entity name after the '&', first character in the low byte
  function automatic logic [39:0] ent_word(input logic [2:0] idx);
    logic [39:0] w;
    w = '0;
    case (idx)
      ENT_AMP:  w = {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61};  // amp;
      ENT_LT:   w = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C};  // lt;
      ENT_GT:   w = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67};  // gt;
      ENT_QUOT: w = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71};  // quot;
      ENT_APOS: w = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61};  // apos;
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] idx);
    logic [2:0] n;
    n = 3'd0;
    case (idx)
      ENT_AMP:  n = 3'd4;
      ENT_LT:   n = 3'd3;
      ENT_GT:   n = 3'd3;
      ENT_QUOT: n = 3'd5;
      ENT_APOS: n = 3'd5;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_sym(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      ENT_AMP:  c = 8'h26;  // &
      ENT_LT:   c = 8'h3C;  // <
      ENT_GT:   c = 8'h3E;  // >
      ENT_QUOT: c = 8'h22;  // "
      ENT_APOS: c = 8'h27;  // '
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  // Character at position pos of an entity name, zero past its end
  function automatic logic [7:0] ent_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [39:0] w;
    logic [7:0]  c;
    w = ent_word(idx);
    c = 8'h00;
    if (pos < 3'd5) begin
      c = w[{pos, 3'b000} +: 8];
    end
    return c;
  endfunction

  // Byte k of a held run: the '&' then a prefix of the entity name
  function automatic logic [7:0] held_byte(input logic [2:0] src, input logic [2:0] k);
    logic [7:0] c;
    if (k == 3'd0) begin
      c = CH_AMP;
    end else begin
      c = ent_char(src, k - 3'd1);
    end
    return c;
  endfunction

  // Lowest candidate still set, amp when the mask is empty
  function automatic logic [2:0] first_cand(input logic [4:0] mask);
    logic [2:0] s;
    s = ENT_AMP;
    for (int i = ENT_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        s = 3'(i);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/xml_entity_decoder_core.sv
// Top level of the XML predefined entity decoder.
// Decodes &amp; &lt; &gt; &quot; and &apos; in a byte stream, one value per
// tlast-terminated run; any other '&' run is passed through literally and an
// unfinished one is flushed at the value's last byte. Bytes enter through an
// input register and are decoded in one pass into a group of up to six result
// bytes held in a group register; the serialiser then emits that group one
// byte per beat. Input is taken every cycle while groups are one byte or
// empty and the output is not stalled; a larger group holds the input until
// all its bytes are emitted, which evens out since bytes held inside an
// entity produce nothing when taken. The first result beat passes through
// the input register and then the group register before it is presented.
// Reset needs no clearing pass.
module xml_entity_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // out_last
);
  import xed_pkg::*;

  xed_group_t grp;
  logic       grp_valid;
  logic       grp_ready;

  xed_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .grp_o       (grp),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready)
  );

  xed_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .grp_i       (grp),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

>>> rtl/xed_decode.sv
// Input register, match state and single-pass decode of one byte into a result group.
module xed_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,    // [7:0] in_byte
  input  logic               in_tlast,
  output xed_pkg::xed_group_t grp_o,
  output logic               grp_valid_o,
  input  logic               grp_ready_i
);
  import xed_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic [2:0] held_r,  held_nxt;
  logic [4:0] mask_r,  mask_nxt;

  logic [2:0] pos;
  logic [2:0] src_old, src_new;
  logic [4:0] match;
  logic       complete;
  logic [2:0] comp_idx;
  logic       brk;
  logic       is_amp;
  logic [2:0] a_len, c_len;
  logic       b_vld;
  logic [7:0] b_byte;
  logic [2:0] held_mid;
  logic [4:0] mask_mid;
  logic [2:0] cnt;
  logic       dec_fire;

  // Candidate match of the current byte against the held prefix
  always_comb begin
    pos      = held_r - 3'd1;
    match    = '0;
    complete = 1'b0;
    comp_idx = ENT_AMP;
    for (int i = 0; i < ENT_COUNT; i++) begin
      if (mask_r[i] && (pos < ent_len(3'(i))) && (ent_char(3'(i), pos) == in_byte_r)) begin
        match[i] = 1'b1;
        if (pos + 3'd1 == ent_len(3'(i))) begin
          complete = 1'b1;
          comp_idx = 3'(i);
        end
      end
    end
  end

  assign src_old = first_cand(mask_r);
  assign is_amp  = (in_byte_r == CH_AMP);
  assign brk     = (held_r != 3'd0) && (match == 5'd0);
  assign a_len   = brk ? held_r : 3'd0;

  // Byte handling after any broken hold is released
  always_comb begin
    b_vld    = 1'b0;
    b_byte   = in_byte_r;
    held_mid = 3'd0;
    mask_mid = 5'd0;
    if ((held_r == 3'd0) || brk) begin
      if (is_amp) begin
        held_mid = 3'd1;
        mask_mid = ALL_CAND;
      end else begin
        b_vld = 1'b1;
      end
    end else if (complete) begin
      b_vld  = 1'b1;
      b_byte = ent_sym(comp_idx);
    end else begin
      held_mid = held_r + 3'd1;
      mask_mid = match;
    end
  end

  // End of value flushes whatever is still held
  assign src_new  = first_cand(mask_mid);
  assign c_len    = in_last_r ? held_mid : 3'd0;
  assign held_nxt = in_last_r ? 3'd0 : held_mid;
  assign mask_nxt = in_last_r ? 5'd0 : mask_mid;
  assign cnt      = a_len + {2'b00, b_vld} + c_len;

  // Lay out released bytes: old hold, then the byte, then the flushed hold
  always_comb begin
    logic [2:0] k;
    grp_o.cnt  = cnt;
    grp_o.last = in_last_r;
    for (int j = 0; j < GRP_MAX; j++) begin
      k = 3'(j) - a_len - {2'b00, b_vld};
      if (3'(j) < a_len) begin
        grp_o.bytes[j] = held_byte(src_old, 3'(j));
      end else if ((3'(j) == a_len) && b_vld) begin
        grp_o.bytes[j] = b_byte;
      end else begin
        grp_o.bytes[j] = held_byte(src_new, k);
      end
    end
  end

  // An item with nothing to release never waits for the serialiser
  assign dec_fire    = in_valid_r && (grp_ready_i || (cnt == 3'd0));
  assign grp_valid_o = in_valid_r && (cnt != 3'd0);
  assign in_tready   = !in_valid_r || dec_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      held_r     <= 3'd0;
      mask_r     <= 5'd0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (dec_fire) begin
        held_r <= held_nxt;
        mask_r <= mask_nxt;
      end
    end
  end

  // Input payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

endmodule

>>> rtl/xed_serial.sv
// Result group register and byte-per-beat output serialiser.
module xed_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  xed_pkg::xed_group_t grp_i,
  input  logic                grp_valid_i,
  output logic                grp_ready_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [7:0] out_byte
  output logic                out_tlast
);
  import xed_pkg::*;

  xed_group_t grp_r;
  logic       grp_valid_r;
  logic [2:0] idx_r;
  logic       last_beat;
  logic       take;

  assign last_beat   = (idx_r == grp_r.cnt - 3'd1);
  assign take        = grp_valid_r && out_tready && last_beat;
  assign grp_ready_o = !grp_valid_r || take;

  assign out_tvalid = grp_valid_r;
  assign out_tdata  = grp_r.bytes[idx_r];
  assign out_tlast  = grp_r.last && last_beat;

  // Group occupancy and beat index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (grp_ready_o) begin
      grp_valid_r <= grp_valid_i;
      idx_r       <= 3'd0;
    end else if (out_tvalid && out_tready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // Group payload
  always_ff @(posedge clk) begin
    if (grp_ready_o && grp_valid_i) begin
      grp_r <= grp_i;
    end
  end

endmodule

>>> rtl/xed_checker.sv
// Port-level checks for the entity decoder, bound to the top level.
module xed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic        in_fire, out_fire;
  logic [15:0] byte_bal_r;
  logic [7:0]  frame_bal_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Bytes and values taken but not yet fully delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_bal_r  <= 16'd0;
      frame_bal_r <= 8'd0;
    end else begin
      byte_bal_r  <= byte_bal_r + {15'd0, in_fire} - {15'd0, out_fire};
      frame_bal_r <= frame_bal_r + {7'd0, in_fire && in_tlast}
                     - {7'd0, out_fire && out_tlast};
    end
  end

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_no_excess: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> byte_bal_r != 16'd0)
    else $error("more output bytes than input bytes");

  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |-> frame_bal_r != 8'd0)
    else $error("value end emitted before its last input byte");

endmodule

bind xml_entity_decoder_core xed_checker u_xed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
